// ===== src/mrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared constants, types and helpers for the meter reply frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    localparam int FRAME_BYTES = 22;
    localparam int POS_W       = 5;
    localparam int ADDR_W      = 56;
    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 2;
    localparam int READING_W   = 28;
    localparam int WEIGHT_W    = 20;
    localparam int DIGIT_W     = 8;
    localparam int OUT_DATA_W  = 32;

    localparam logic [BYTE_W-1:0] START_BYTE   = 8'h68;
    localparam logic [BYTE_W-1:0] CONTROL_BYTE = 8'h10;

    localparam logic [POS_W-1:0] POS_HUNT       = 5'd0;
    localparam logic [POS_W-1:0] POS_CONTROL    = 5'd1;
    localparam logic [POS_W-1:0] POS_ADDR_FIRST = 5'd2;
    localparam logic [POS_W-1:0] POS_ADDR_LAST  = 5'd8;
    localparam logic [POS_W-1:0] POS_READ_FIRST = 5'd14;
    localparam logic [POS_W-1:0] POS_READ_LAST  = 5'd17;
    localparam logic [POS_W-1:0] POS_SUM        = 5'd20;
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_BYTES - 1);

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ADDR_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SUM_ERR  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_HDR_ERR  = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]  frame_status;
        logic [READING_W-1:0] reading_hundredths;
    } mrfc_result_t;

    // Weight of one BCD byte of the reading, lowest byte first.
    function automatic logic [WEIGHT_W-1:0] pair_weight(input logic [1:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            2'd0:    w = 20'd1;
            2'd1:    w = 20'd100;
            2'd2:    w = 20'd10000;
            2'd3:    w = 20'd1000000;
            default: w = 20'd1;
        endcase
        return w;
    endfunction

endpackage

// ===== src/mrfc_frame_parser.sv =====
// ----------------------------------------------------------------------------
// mrfc_frame_parser
// Input byte register and per-byte frame state update; emits one result
// per complete frame or header error.
// ----------------------------------------------------------------------------
module mrfc_frame_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mrfc_pkg::BYTE_W-1:0]  in_byte,
    input  logic [mrfc_pkg::ADDR_W-1:0]  meter_address,
    input  logic                         res_space,
    output logic                         res_valid,
    output mrfc_pkg::mrfc_result_t       res_data
);
    import mrfc_pkg::*;

    logic                  byte_vld_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [BYTE_W-1:0]     sum_reg, sum_next;
    logic                  diff_reg, diff_next;
    logic [READING_W-1:0]  acc_reg, acc_next;

    logic                  take;
    logic [2:0]            addr_idx;
    logic [BYTE_W-1:0]     expect_byte;
    logic [1:0]            read_idx;
    logic [DIGIT_W-1:0]    digit_pair;
    logic [READING_W-1:0]  term;

    assign take     = byte_vld_reg && res_space;
    assign in_ready = !byte_vld_reg || res_space;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_vld_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            byte_vld_reg <= 1'b1;
        end else if (take) begin
            byte_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            byte_reg <= in_byte;
        end
    end

    // Address byte for this position; byte 2 sits in the lowest eight bits.
    assign addr_idx    = 3'(pos_reg - POS_ADDR_FIRST);
    assign expect_byte = meter_address[addr_idx*BYTE_W +: BYTE_W];

    // Each reading byte counts as two decimal digits, nibbles unchecked.
    assign read_idx   = 2'(pos_reg - POS_READ_FIRST);
    assign digit_pair = DIGIT_W'(byte_reg[3:0]) + DIGIT_W'(byte_reg[7:4]) * DIGIT_W'(10);
    assign term       = READING_W'(digit_pair) * READING_W'(pair_weight(read_idx));

    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        diff_next = diff_reg;
        acc_next  = acc_reg;
        res_valid = 1'b0;
        res_data  = '0;
        if (take) begin
            if (pos_reg == POS_HUNT) begin
                if (byte_reg == START_BYTE) begin
                    sum_next  = byte_reg;
                    diff_next = 1'b0;
                    acc_next  = '0;
                    pos_next  = POS_CONTROL;
                end
            end else if (pos_reg == POS_CONTROL) begin
                if (byte_reg != CONTROL_BYTE) begin
                    pos_next  = POS_HUNT;
                    sum_next  = '0;
                    diff_next = 1'b0;
                    acc_next  = '0;
                    res_valid = 1'b1;
                    res_data.frame_status = STATUS_HDR_ERR;
                end else begin
                    sum_next = sum_reg + byte_reg;
                    pos_next = POS_ADDR_FIRST;
                end
            end else begin
                if (pos_reg >= POS_ADDR_FIRST && pos_reg <= POS_ADDR_LAST &&
                    expect_byte != byte_reg) begin
                    diff_next = 1'b1;
                end
                if (pos_reg >= POS_READ_FIRST && pos_reg <= POS_READ_LAST) begin
                    acc_next = acc_reg + term;
                end
                if (pos_reg < POS_SUM) begin
                    sum_next = sum_reg + byte_reg;
                end else if (pos_reg == POS_SUM) begin
                    sum_next = sum_reg - byte_reg;
                end
                if (pos_reg >= POS_LAST) begin
                    res_valid = 1'b1;
                    if (diff_next) begin
                        res_data.frame_status = STATUS_ADDR_ERR;
                    end else if (sum_next != '0) begin
                        res_data.frame_status = STATUS_SUM_ERR;
                    end else begin
                        res_data.frame_status       = STATUS_OK;
                        res_data.reading_hundredths = acc_next;
                    end
                    pos_next  = POS_HUNT;
                    sum_next  = '0;
                    diff_next = 1'b0;
                    acc_next  = '0;
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_HUNT;
            sum_reg  <= '0;
            diff_reg <= 1'b0;
            acc_reg  <= '0;
        end else begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            diff_reg <= diff_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

// ===== src/mrfc_result_buffer.sv =====
// ----------------------------------------------------------------------------
// mrfc_result_buffer
// Two-entry result register that decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module mrfc_result_buffer (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_valid,
    input  mrfc_pkg::mrfc_result_t  wr_data,
    output logic                    wr_space,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output mrfc_pkg::mrfc_result_t  rd_data
);
    import mrfc_pkg::*;

    mrfc_result_t entry_reg [2];
    logic [1:0]   count_reg, count_next;
    logic         head_reg;
    logic         wr_ptr;
    logic         pop;

    assign wr_space = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = entry_reg[head_reg];
    assign pop      = rd_valid && rd_ready;
    assign wr_ptr   = head_reg ^ count_reg[0];

    always_comb begin
        count_next = count_reg;
        if (wr_valid && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!wr_valid && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
            head_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (pop) begin
                head_reg <= !head_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            entry_reg[wr_ptr] <= wr_data;
        end
    end

endmodule

// ===== src/meter_reply_frame_checker.sv =====
// ----------------------------------------------------------------------------
// meter_reply_frame_checker
// Hunts meter reply frames in a received byte stream, checks header, address
// and checksum, and reports the status and decoded reading of each frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] rx_byte
//  m_axis    out        tdata[1:0] frame_status, [29:2] reading_hundredths
//  cfg       in         cfg_wdata[55:0] meter_address
//
// One byte is accepted per cycle while s_tready is high. A byte is registered on
// entry and handled once the result buffer has space; its result is then written
// into the result buffer, which drives m_axis.
// Reset clears the frame state, the meter address and the result buffer.
// A two-entry result buffer absorbs m_tready stalls; s_tready drops only
// while both entries hold results and a byte waits in the input register.
// ----------------------------------------------------------------------------
module meter_reply_frame_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mrfc_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] frame_status, [29:2] reading_hundredths, [31:30] zero
    output logic [mrfc_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wen,
    input  logic [mrfc_pkg::ADDR_W-1:0]         cfg_wdata
);
    import mrfc_pkg::*;

    logic [ADDR_W-1:0] meter_address_reg;
    logic              res_space;
    logic              res_valid;
    mrfc_result_t      res_data;
    mrfc_result_t      out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meter_address_reg <= '0;
        end else if (cfg_wen) begin
            meter_address_reg <= cfg_wdata;
        end
    end

    mrfc_frame_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_byte       (s_tdata),
        .meter_address (meter_address_reg),
        .res_space     (res_space),
        .res_valid     (res_valid),
        .res_data      (res_data)
    );

    mrfc_result_buffer u_result_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (res_valid),
        .wr_data  (res_data),
        .wr_space (res_space),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_data)
    );

    assign m_tdata = {2'b00, out_data.reading_hundredths, out_data.frame_status};

endmodule
